@@ hw/rtl/sdps_pkg.sv @@
// Package for the sphere diffuse pixel shader: word types, register codes and step functions.
package sdps_pkg;

    typedef struct packed {
        logic signed [7:0] pixel_x;
        logic signed [7:0] pixel_y;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       on_sphere;
    } t_pix_out;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPHERE_COL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_COL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AMBIENT    = 3'd6;

    // Steps of the square-root and divider chains.
    localparam int SQ_N = 8;
    localparam int DV_N = 8;

    // ceil(2^23/127) and ceil(2^24/255): exact reciprocals over the value ranges used.
    localparam logic [16:0] K_DIV127 = 17'd66053;
    localparam logic [16:0] K_DIV255 = 17'd65794;

    typedef struct packed {
        logic [9:0]  rem;
        logic [7:0]  root;
        logic [15:0] rad;
    } t_sq;

    typedef struct packed {
        logic [14:0] rem;
        logic [7:0]  q;
    } t_dv;

    typedef struct packed {
        logic       on;
        logic       sx;
        logic       sy;
        logic [7:0] ax;
        logic [7:0] ay;
    } t_side_a;

    typedef struct packed {
        logic on;
        logic sx;
        logic sy;
    } t_side_b;

    typedef struct packed {
        logic            on;
        logic            sx;
        logic            sy;
        logic [2:0][7:0] q;
    } t_side_c;

    typedef struct packed {
        logic       on;
        logic       sx;
        logic       sy;
        logic [7:0] len;
    } t_side_d;

    // One digit of a floor square root: brings down two radicand bits.
    function automatic t_sq sqrt_step(t_sq s);
        t_sq        o;
        logic [11:0] rem2;
        logic [11:0] trial;
        rem2  = {s.rem, s.rad[15:14]};
        trial = {2'b00, s.root, 2'b01};
        o.rad = {s.rad[13:0], 2'b00};
        if (rem2 >= trial) begin
            o.rem  = 10'(rem2 - trial);
            o.root = {s.root[6:0], 1'b1};
        end else begin
            o.rem  = rem2[9:0];
            o.root = {s.root[6:0], 1'b0};
        end
        return o;
    endfunction

    // One quotient bit of a restoring divide; the quotient is known to fit in eight bits.
    function automatic t_dv div_step(t_dv s, logic [7:0] dvs, logic [2:0] sh);
        t_dv         o;
        logic [15:0] dsh;
        dsh = 16'(dvs) << sh;
        o   = s;
        if ({1'b0, s.rem} >= dsh) begin
            o.rem = 15'({1'b0, s.rem} - dsh);
            o.q   = s.q | (8'd1 << sh);
        end
        return o;
    endfunction

    function automatic logic [14:0] times127(logic [7:0] m);
        return {m, 7'b0} - 15'(m);
    endfunction

endpackage

@@ hw/rtl/sphere_diffuse_pixel_shader_top.sv @@
// Sphere diffuse pixel shader: one Lambert-shaded pixel per input word.
// Throughput is one word per cycle; the 43-stage pipeline freezes as a whole, empty stages
// included, while a finished word waits at the output and the receiver stalls.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults.
module sphere_diffuse_pixel_shader_top #(
    parameter int IMAGE_SIZE = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  sdps_pkg::t_pix_in               i_pix,
    output logic                            o_valid,
    input  logic                            i_stall,
    output sdps_pkg::t_pix_out              o_pix,
    input  logic                            i_cfg_we,
    input  logic [sdps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sdps_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sdps_pkg::*;

    localparam int HALF = IMAGE_SIZE / 2;
    localparam logic signed [9:0] HALF_POS = 10'(HALF);
    localparam logic signed [9:0] HALF_NEG = 10'(-HALF);
    // Input stage, disc test, two square roots, two divides, two squared-length stages, seven shading stages.
    localparam int NSTG = 2 + 2 * SQ_N + 2 * DV_N + 2 + 7;

    // Configuration registers.
    logic [7:0]        r_radius;
    logic signed [7:0] r_light_x;
    logic signed [7:0] r_light_y;
    logic signed [7:0] r_light_z;
    logic [23:0]       r_sphere_col;
    logic [23:0]       r_back_col;
    logic [7:0]        r_ambient;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius     <= 8'd80;
            r_light_x    <= 8'sd57;
            r_light_y    <= -8'sd5;
            r_light_z    <= 8'sd115;
            r_sphere_col <= 24'hC83232;
            r_back_col   <= 24'h0F0F64;
            r_ambient    <= 8'd50;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RADIUS:     r_radius     <= i_cfg_data[7:0];
                REG_LIGHT_X:    r_light_x    <= i_cfg_data[7:0];
                REG_LIGHT_Y:    r_light_y    <= i_cfg_data[7:0];
                REG_LIGHT_Z:    r_light_z    <= i_cfg_data[7:0];
                REG_SPHERE_COL: r_sphere_col <= i_cfg_data;
                REG_BACK_COL:   r_back_col   <= i_cfg_data;
                REG_AMBIENT:    r_ambient    <= i_cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    // The whole pipeline moves together. It only holds when the output word is
    // waiting and the receiver stalls; an empty output stage always lets it advance.
    logic            w_en;
    logic [NSTG-1:0] r_vld;

    assign w_en    = !(r_vld[NSTG-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // Stage 1: bounds check, magnitudes and squares.
    logic signed [9:0] w_xe, w_ye;
    logic              r1_oob, r1_sx, r1_sy;
    logic [7:0]        r1_ax, r1_ay;
    logic [15:0]       r1_xx, r1_yy, r1_r2;
    logic [7:0]        w_ax, w_ay;

    assign w_xe = {{2{i_pix.pixel_x[7]}}, i_pix.pixel_x};
    assign w_ye = {{2{i_pix.pixel_y[7]}}, i_pix.pixel_y};
    assign w_ax = i_pix.pixel_x[7] ? 8'(-i_pix.pixel_x) : i_pix.pixel_x;
    assign w_ay = i_pix.pixel_y[7] ? 8'(-i_pix.pixel_y) : i_pix.pixel_y;

    // Stage 2: disc test and the radicand for the depth.
    logic        r2_on, r2_sx, r2_sy;
    logic [7:0]  r2_ax, r2_ay;
    logic [15:0] r2_d;
    logic [16:0] w_dist2;

    assign w_dist2 = 17'(r1_xx) + 17'(r1_yy);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_oob <= (w_xe < HALF_NEG) || (w_xe >= HALF_POS) ||
                      (w_ye < HALF_NEG) || (w_ye >= HALF_POS) || (r_radius == 8'd0);
            r1_sx  <= i_pix.pixel_x[7];
            r1_sy  <= i_pix.pixel_y[7];
            r1_ax  <= w_ax;
            r1_ay  <= w_ay;
            r1_xx  <= w_ax * w_ax;
            r1_yy  <= w_ay * w_ay;
            r1_r2  <= r_radius * r_radius;
            r2_on  <= !r1_oob && (w_dist2 <= 17'(r1_r2));
            r2_sx  <= r1_sx;
            r2_sy  <= r1_sy;
            r2_ax  <= r1_ax;
            r2_ay  <= r1_ay;
            r2_d   <= r1_r2 - w_dist2[15:0];
        end
    end

    // Depth: floor square root, one digit per stage.
    t_sq     r_sq    [SQ_N];
    t_side_a r_sq_sd [SQ_N];
    t_sq     w_sq0;
    t_side_a w_sd0;

    assign w_sq0 = '{rem: '0, root: '0, rad: r2_d};
    assign w_sd0 = '{on: r2_on, sx: r2_sx, sy: r2_sy, ax: r2_ax, ay: r2_ay};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < SQ_N; k++) begin
                if (k == 0) begin
                    r_sq[k]    <= sqrt_step(w_sq0);
                    r_sq_sd[k] <= w_sd0;
                end else begin
                    r_sq[k]    <= sqrt_step(r_sq[k-1]);
                    r_sq_sd[k] <= r_sq_sd[k-1];
                end
            end
        end
    end

    // Normal scaled by 127/radius: three lanes of restoring division.
    t_dv     r_d1    [DV_N][3];
    t_side_b r_d1_sd [DV_N];
    t_dv     w_d1_in [3];

    assign w_d1_in[0] = '{rem: times127(r_sq_sd[SQ_N-1].ax), q: '0};
    assign w_d1_in[1] = '{rem: times127(r_sq_sd[SQ_N-1].ay), q: '0};
    assign w_d1_in[2] = '{rem: times127(r_sq[SQ_N-1].root), q: '0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < DV_N; k++) begin
                for (int j = 0; j < 3; j++) begin
                    if (k == 0) begin
                        r_d1[k][j] <= div_step(w_d1_in[j], r_radius, 3'(DV_N - 1 - k));
                    end else begin
                        r_d1[k][j] <= div_step(r_d1[k-1][j], r_radius, 3'(DV_N - 1 - k));
                    end
                end
                if (k == 0) begin
                    r_d1_sd[k] <= '{on: r_sq_sd[SQ_N-1].on, sx: r_sq_sd[SQ_N-1].sx,
                                    sy: r_sq_sd[SQ_N-1].sy};
                end else begin
                    r_d1_sd[k] <= r_d1_sd[k-1];
                end
            end
        end
    end

    // Squared length of the normal.
    logic [2:0][7:0]  r_sq_q, r_sum_q;
    logic [2:0][15:0] r_sq_p;
    logic [15:0]      r_sum;
    t_side_b          r_sq_psd, r_sum_sd;
    logic [16:0]      w_len2;

    assign w_len2 = 17'(r_sq_p[0]) + 17'(r_sq_p[1]) + 17'(r_sq_p[2]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r_sq_q[j] <= r_d1[DV_N-1][j].q;
                r_sq_p[j] <= r_d1[DV_N-1][j].q * r_d1[DV_N-1][j].q;
            end
            r_sq_psd <= r_d1_sd[DV_N-1];
            r_sum    <= w_len2[15:0];
            r_sum_q  <= r_sq_q;
            r_sum_sd <= r_sq_psd;
        end
    end

    // Length of the normal: second floor square root.
    t_sq     r_sq2    [SQ_N];
    t_side_c r_sq2_sd [SQ_N];
    t_sq     w_sq2_0;

    assign w_sq2_0 = '{rem: '0, root: '0, rad: r_sum};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < SQ_N; k++) begin
                if (k == 0) begin
                    r_sq2[k]    <= sqrt_step(w_sq2_0);
                    r_sq2_sd[k] <= '{on: r_sum_sd.on, sx: r_sum_sd.sx, sy: r_sum_sd.sy,
                                     q: r_sum_q};
                end else begin
                    r_sq2[k]    <= sqrt_step(r_sq2[k-1]);
                    r_sq2_sd[k] <= r_sq2_sd[k-1];
                end
            end
        end
    end

    // Renormalisation: each component times 127 divided by the length.
    t_dv     r_d2    [DV_N][3];
    t_side_d r_d2_sd [DV_N];
    t_dv     w_d2_in [3];
    logic [7:0] w_len;

    assign w_len = r_sq2[SQ_N-1].root;
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_d2_in[j] = '{rem: times127(r_sq2_sd[SQ_N-1].q[j]), q: '0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < DV_N; k++) begin
                for (int j = 0; j < 3; j++) begin
                    if (k == 0) begin
                        r_d2[k][j] <= div_step(w_d2_in[j], w_len, 3'(DV_N - 1 - k));
                    end else begin
                        r_d2[k][j] <= div_step(r_d2[k-1][j], r_d2_sd[k-1].len,
                                               3'(DV_N - 1 - k));
                    end
                end
                if (k == 0) begin
                    r_d2_sd[k] <= '{on: r_sq2_sd[SQ_N-1].on, sx: r_sq2_sd[SQ_N-1].sx,
                                    sy: r_sq2_sd[SQ_N-1].sy, len: w_len};
                end else begin
                    r_d2_sd[k] <= r_d2_sd[k-1];
                end
            end
        end
    end

    // Shading: dot product, clamp, intensity, colour scaling.
    logic signed [7:0]  w_nx, w_ny, w_nz;
    logic               w_lz;
    logic signed [15:0] r_px, r_py, r_pz;
    logic signed [17:0] w_dot_sum;
    logic [15:0]        r_m;
    logic [32:0]        r_mk;
    logic [8:0]         w_dot, w_int9;
    logic [7:0]         w_int, r_int;
    logic [2:0][15:0]   r_cp;
    logic [2:0][32:0]   r_ck;
    logic [5:0]         r_on_sh;
    t_pix_out           r_out;
    t_side_d            w_dsd;

    assign w_dsd = r_d2_sd[DV_N-1];
    assign w_lz  = (w_dsd.len == 8'd0);
    // A zero-length normal shades with the ambient floor only.
    assign w_nx  = w_lz ? 8'sd0 : (w_dsd.sx ? -$signed(r_d2[DV_N-1][0].q)
                                            :  $signed(r_d2[DV_N-1][0].q));
    assign w_ny  = w_lz ? 8'sd0 : (w_dsd.sy ? -$signed(r_d2[DV_N-1][1].q)
                                            :  $signed(r_d2[DV_N-1][1].q));
    assign w_nz  = w_lz ? 8'sd0 : $signed(r_d2[DV_N-1][2].q);

    assign w_dot_sum = 18'(r_px) + 18'(r_py) + 18'(r_pz);

    // dot = m/127 by reciprocal; intensity = dot*255/127, which is 2*dot plus one
    // at dot = 127 and saturates above that.
    assign w_dot  = r_mk[31:23];
    assign w_int9 = {w_dot[7:0], 1'b0} + 9'(w_dot == 9'd127);
    always_comb begin
        if (w_dot >= 9'd128) begin
            w_int = 8'd255;
        end else begin
            w_int = w_int9[7:0];
        end
        if (w_int < r_ambient) begin
            w_int = r_ambient;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px    <= w_nx * r_light_x;
            r_py    <= w_ny * r_light_y;
            r_pz    <= w_nz * r_light_z;
            r_m     <= w_dot_sum[17] ? 16'd0 : w_dot_sum[15:0];
            r_mk    <= 33'(r_m) * 33'(K_DIV127);
            r_int   <= w_int;
            for (int j = 0; j < 3; j++) begin
                r_cp[j] <= r_int * r_sphere_col[8*(2-j) +: 8];
                r_ck[j] <= 33'(r_cp[j]) * 33'(K_DIV255);
            end
            r_on_sh <= {r_on_sh[4:0], w_dsd.on};
            if (r_on_sh[5]) begin
                r_out <= '{red: r_ck[0][31:24], green: r_ck[1][31:24],
                           blue: r_ck[2][31:24], on_sphere: 1'b1};
            end else begin
                r_out <= '{red: r_back_col[23:16], green: r_back_col[15:8],
                           blue: r_back_col[7:0], on_sphere: 1'b0};
            end
        end
    end

    assign o_pix = r_out;

    // A frozen pipeline keeps every valid bit where it is.
    a_freeze_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_vld))
        else $error("pipeline valid bits moved while frozen");

    // Only a waiting output word can freeze the pipeline.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall without a waiting output word");

    // An accepted word enters the first stage.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted word lost at entry");

    // The depth square root ends with a remainder no larger than twice its root.
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1 + SQ_N] |-> (r_sq[SQ_N-1].rem <= {1'b0, r_sq[SQ_N-1].root, 1'b0}))
        else $error("square root remainder out of range");

endmodule

@@ sim/tb_top.sv @@
// Testbench for the sphere diffuse pixel shader: random and directed pixels checked against a shading predictor.
module tb_top;
    import sdps_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    t_pix_in               i_pix;
    logic                  o_valid;
    logic                  i_stall;
    t_pix_out              o_pix;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sphere_diffuse_pixel_shader_top i_dut (.*);

    // The predictor's own copy of the registers.
    int unsigned pm_radius;
    int          pm_lx, pm_ly, pm_lz;
    logic [23:0] pm_sphere, pm_back;
    int unsigned pm_ambient;

    t_pix_out    shaded_q[$];
    int          n_bad;
    bit          timed_out;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;
    int          quiet_cycles;

    localparam int LATENCY   = 43;
    localparam int WATCHDOG  = 5000;

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    function automatic int unsigned isqrt(int unsigned n);
        int unsigned r;
        r = 0;
        while ((r + 1) * (r + 1) <= n) r++;
        return r;
    endfunction

    // Works out the shaded pixel for one coordinate under the current settings.
    function automatic t_pix_out shade_pixel(logic signed [7:0] px, logic signed [7:0] py);
        t_pix_out o;
        int x, y, r, nz, nx, ny, nzz, len, dot, inten;
        x = px;
        y = py;
        r = pm_radius;
        o.on_sphere = 1'b0;
        {o.red, o.green, o.blue} = pm_back;
        if (r == 0 || x * x + y * y > r * r) return o;
        nz  = isqrt(r * r - x * x - y * y);
        nx  = (x * 127) / r;
        ny  = (y * 127) / r;
        nzz = (nz * 127) / r;
        len = isqrt(nx * nx + ny * ny + nzz * nzz);
        if (len != 0) begin
            nx = (nx * 127) / len;
            ny = (ny * 127) / len;
            nzz = (nzz * 127) / len;
        end else begin
            nx = 0; ny = 0; nzz = 0;
        end
        dot = (nx * pm_lx + ny * pm_ly + nzz * pm_lz) / 127;
        if (dot < 0) dot = 0;
        inten = (dot * 255) / 127;
        if (inten < int'(pm_ambient)) inten = pm_ambient;
        if (inten > 255) inten = 255;
        o.red   = 8'((inten * pm_sphere[23:16]) / 255);
        o.green = 8'((inten * pm_sphere[15:8]) / 255);
        o.blue  = 8'((inten * pm_sphere[7:0]) / 255);
        o.on_sphere = 1'b1;
        return o;
    endfunction

    // Register write; the predictor's copy follows it.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_RADIUS:     pm_radius = val[7:0];
            REG_LIGHT_X:    pm_lx = $signed(val[7:0]);
            REG_LIGHT_Y:    pm_ly = $signed(val[7:0]);
            REG_LIGHT_Z:    pm_lz = $signed(val[7:0]);
            REG_SPHERE_COL: pm_sphere = val;
            REG_BACK_COL:   pm_back = val;
            REG_AMBIENT:    pm_ambient = val[7:0];
            default: ;
        endcase
    endtask

    task automatic write_all(int r, int lx, int ly, int lz, logic [23:0] sc,
                             logic [23:0] bc, int amb);
        write_reg(REG_RADIUS, 24'(r));
        write_reg(REG_LIGHT_X, 24'(lx));
        write_reg(REG_LIGHT_Y, 24'(ly));
        write_reg(REG_LIGHT_Z, 24'(lz));
        write_reg(REG_SPHERE_COL, sc);
        write_reg(REG_BACK_COL, bc);
        write_reg(REG_AMBIENT, 24'(amb));
    endtask

    // Sends one pixel word, holding it until the block takes it. Valid stays high
    // afterwards so that the next word can follow straight on; idling drops it.
    task automatic send_pixel(logic signed [7:0] px, logic signed [7:0] py);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pix   <= '{pixel_x: px, pixel_y: py};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        shaded_q.push_back(shade_pixel(px, py));
        @(negedge i_clk);
    endtask

    // Waits until every expected word has come back, then for the pipeline to settle.
    task automatic drain;
        i_valid <= 1'b0;
        while (shaded_q.size() != 0 && !timed_out) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    // Random pixel, mostly near the disc so that the shading path is exercised.
    task automatic send_random(int n);
        int lim;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(3) == 0) send_pixel(8'($urandom), 8'($urandom));
            else begin
                lim = (pm_radius > 127) ? 127 : pm_radius + 1;
                send_pixel(8'($urandom_range(2 * lim) - lim),
                           8'($urandom_range(2 * lim) - lim));
            end
        end
    endtask

    // Corners, axes, the disc rim and the centre.
    task automatic test_directed;
        send_idle_pct = 0; recv_stall_pct = 0;
        send_pixel(0, 0);
        send_pixel(-128, -128);
        send_pixel(127, 127);
        send_pixel(-128, 127);
        send_pixel(127, -128);
        send_pixel(80, 0);
        send_pixel(81, 0);
        send_pixel(0, -80);
        send_pixel(0, 80);
        send_pixel(48, 64);
        send_pixel(-48, -64);
        send_pixel(-57, 57);
        send_pixel(1, -1);
        drain();
    endtask

    // A zero radius hides the sphere; small radii give degenerate normals; the largest radius covers every pixel.
    task automatic test_radius_edges;
        write_reg(REG_RADIUS, 24'd0);
        send_pixel(0, 0);
        send_pixel(1, 0);
        drain();
        write_reg(REG_RADIUS, 24'd1);
        send_pixel(0, 0);
        send_pixel(1, 0);
        send_pixel(1, 1);
        send_pixel(0, -1);
        drain();
        write_reg(REG_RADIUS, 24'd255);
        send_pixel(-128, -128);
        send_pixel(127, 127);
        send_pixel(0, 0);
        drain();
    endtask

    // Random pixels over a sweep of settings and idling patterns.
    task automatic test_random_settings;
        int pct[4][2] = '{'{0, 0}, '{70, 0}, '{0, 70}, '{36, 36}};
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: write_all(128, 127, 127, 127, 24'hFFFFFF, 24'h000000, 0);
                1: write_all(1 + $urandom_range(127), $urandom_range(254) - 127,
                             $urandom_range(254) - 127, $urandom_range(254) - 127,
                             24'($urandom), 24'($urandom), $urandom_range(255));
                2: write_all($urandom_range(255), -128, -128, -128,
                             24'h000000, 24'hFFFFFF, 255);
                default: write_all(1 + $urandom_range(20), $urandom, $urandom, $urandom,
                                   24'($urandom), 24'($urandom), $urandom_range(80));
            endcase
            send_idle_pct  = pct[ph % 4][0];
            recv_stall_pct = pct[ph % 4][1];
            send_random(125);
            drain();
        end
    endtask

    // The receiver holds off long enough for the pipeline to fill and push back.
    task automatic test_back_pressure;
        write_all(80, 57, -5, 115, 24'hC83232, 24'h0F0F64, 50);
        send_idle_pct = 0; recv_stall_pct = 10;
        fork
            send_random(120);
            begin
                @(negedge i_clk);
                hold_off = 1'b1;
                repeat (150) @(negedge i_clk);
                hold_off = 1'b0;
            end
        join
        drain();
    endtask

    // Receiver stall, redrawn every falling edge.
    always @(negedge i_clk)
        i_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);

    // Result checker.
    always @(posedge i_clk) begin
        t_pix_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (shaded_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected word %h", o_pix);
            end else begin
                want = shaded_q.pop_front();
                if (o_pix.red !== want.red || o_pix.green !== want.green ||
                    o_pix.blue !== want.blue || o_pix.on_sphere !== want.on_sphere) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("pixel word: expected %h, got %h", want, o_pix);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG) begin
            timed_out = 1'b1;
            $display("sphere_diffuse_pixel_shader_top: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_pix = '0; i_stall = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        n_bad = 0; timed_out = 1'b0; hold_off = 1'b0; quiet_cycles = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        pm_radius = 80; pm_lx = 57; pm_ly = -5; pm_lz = 115;
        pm_sphere = 24'hC83232; pm_back = 24'h0F0F64; pm_ambient = 50;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_radius_edges();
        test_random_settings();
        test_back_pressure();
        if (n_bad == 0 && shaded_q.size() == 0)
            $display("sphere_diffuse_pixel_shader_top: match");
        else
            $display("sphere_diffuse_pixel_shader_top: mismatch");
        $finish;
    end
endmodule
